FILE: rtl/stable_priority_queue_with_removal_top_defines.svh
// Assertion macros shared by the priority queue RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef STABLE_PRIORITY_QUEUE_WITH_REMOVAL_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_WITH_REMOVAL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// Shared types, codes and constants of the sorted priority queue.
// Used by spq_cell and the top level; depends on nothing.
package spq_pkg;

    localparam int KEY_W    = 16;
    localparam int PRIO_W   = 16;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 4;
    localparam int OCC_W    = 5;
    localparam int DEPTH_DEF = 16;
    localparam int MAX_OUT  = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_SERVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SERVED    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_COUNT     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_ENTRY     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_ADDED_NEW = 4'd9;

    // Commands broadcast to every cell of the chain
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_REM  = 2'd2;
    localparam logic [1:0] CELL_POP  = 2'd3;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [KEY_W-1:0]         key;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        t_entry     ent;
    } t_cell_cmd;

    typedef struct packed {
        logic [OCC_W-1:0]         occ;
        logic signed [PRIO_W-1:0] prio;
        logic [KEY_W-1:0]         key;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } t_result;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast command and takes its own, the left or the right neighbor's data.
// Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occ,      // slot lies below the fill count
    input  spq_pkg::t_entry    i_left,     // entry of the lower neighbor
    input  logic               i_left_le,  // lower neighbor stays on insert
    input  spq_pkg::t_entry    i_right,    // entry of the upper neighbor
    input  logic               i_hit,      // key matched in a lower slot
    output spq_pkg::t_entry    o_ent,
    output logic               o_le,
    output logic               o_hit
);
    import spq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   w_match;

    // Compare against the broadcast entry
    assign o_le    = i_occ && (r_ent.prio <= i_cmd.ent.prio);
    assign w_match = i_occ && (r_ent.key == i_cmd.ent.key);
    assign o_hit   = i_hit || w_match;
    assign o_ent   = r_ent;

    // Pick the next content of the slot
    always_comb begin
        n_ent = r_ent;
        case (i_cmd.op)
            CELL_INS: begin
                if (!o_le) begin
                    n_ent = i_left_le ? i_cmd.ent : i_left;
                end
            end
            CELL_REM: begin
                if (o_hit) begin
                    n_ent = i_right;
                end
            end
            CELL_POP: begin
                n_ent = i_right;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

FILE: rtl/stable_priority_queue_with_removal_top.sv
// Sorted priority queue with removal by key: a chain of DEPTH cells kept in
// ascending priority order, ties in arrival order. Insert, remove and serve
// each make a single pass through the cell chain and count makes none;
// update makes a remove pass, then an insert pass; list takes the
// transaction and then emits one entry per cycle while the output register
// is free, min(count, 16) in all, while a list of an empty queue gives one result.
// A new transaction is taken once the previous one has finished and the
// output register is empty or being drained, so m_axis_tready stalls hold
// back new transactions.
// Depends on spq_pkg, spq_cell and stable_priority_queue_with_removal_top_defines.svh.
`include "stable_priority_queue_with_removal_top_defines.svh"

module stable_priority_queue_with_removal_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // op[2:0], key[18:3], prio[34:19], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[3:0], out_key[19:4], out_prio[35:20],
                                        // occupancy[40:36], zero pad
    output logic        m_axis_tlast
);
    import spq_pkg::*;

    localparam int CW       = $clog2(DEPTH + 1);
    localparam int IW       = $clog2(DEPTH);
    localparam int LIST_MAX = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_lim, n_lim;
    logic          r_upd_found, n_upd_found;
    t_entry        r_upd_ent, n_upd_ent;
    logic          r_ovalid, n_ovalid;
    t_result       r_out, n_out;

    t_cell_cmd     w_cmd;
    logic [1:0]    w_cell_op;
    t_entry        w_in_ent;
    logic [OP_W-1:0] w_op;
    logic          w_out_free;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic          w_found;
    logic [CW-1:0] w_list_n;

    t_entry        w_ent [DEPTH];
    logic          w_le  [DEPTH];
    logic          w_hit [DEPTH];

    // Unpack the input transaction
    assign w_op          = s_axis_tdata[2:0];
    assign w_in_ent.key  = s_axis_tdata[18:3];
    assign w_in_ent.prio = s_axis_tdata[34:19];

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CW'(DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_found       = w_hit[DEPTH-1];
    assign w_list_n      = (r_count > CW'(LIST_MAX)) ? CW'(LIST_MAX) : r_count;

    // Broadcast the command: the held entry during update, else the input one
    assign w_cmd = '{op: w_cell_op, ent: (r_state == S_UPD) ? r_upd_ent : w_in_ent};

    // Chain of cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_le;
        logic   w_hit_in;

        if (gi == 0) begin : g_first
            assign w_left    = w_ent[0];
            assign w_left_le = 1'b1;
            assign w_hit_in  = 1'b0;
        end else begin : g_mid
            assign w_left    = w_ent[gi-1];
            assign w_left_le = w_le[gi-1];
            assign w_hit_in  = w_hit[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right = w_ent[gi];
        end else begin : g_inner
            assign w_right = w_ent[gi+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_occ     (CW'(gi) < r_count),
            .i_left    (w_left),
            .i_left_le (w_left_le),
            .i_right   (w_right),
            .i_hit     (w_hit_in),
            .o_ent     (w_ent[gi]),
            .o_le      (w_le[gi]),
            .o_hit     (w_hit[gi])
        );
    end

    // Sequence operations and build results
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_lim       = r_lim;
        n_upd_found = r_upd_found;
        n_upd_ent   = r_upd_ent;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_out       = r_out;
        w_cell_op   = CELL_HOLD;

        // Defaults for a fresh single result
        if (w_accept || (r_state != S_IDLE && w_out_free)) begin
            n_out.key    = '0;
            n_out.prio   = '0;
            n_out.last   = 1'b1;
            n_out.status = ST_COUNT;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    case (w_op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_cell_op    = CELL_INS;
                                n_count      = r_count + CW'(1);
                                n_out.status = ST_ADDED;
                            end
                        end
                        OP_REMOVE: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else if (w_found) begin
                                w_cell_op    = CELL_REM;
                                n_count      = r_count - CW'(1);
                                n_out.status = ST_REMOVED;
                            end else begin
                                n_out.status = ST_NOT_FOUND;
                            end
                        end
                        OP_UPDATE: begin
                            // Remove pass now, insert pass in S_UPD once the output is free
                            n_ovalid    = r_ovalid && !m_axis_tready;
                            n_upd_found = w_found;
                            n_upd_ent   = w_in_ent;
                            n_state     = S_UPD;
                            if (w_found) begin
                                w_cell_op = CELL_REM;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        OP_SERVE: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                w_cell_op    = CELL_POP;
                                n_count      = r_count - CW'(1);
                                n_out.status = ST_SERVED;
                                n_out.key    = w_ent[0].key;
                                n_out.prio   = w_ent[0].prio;
                            end
                        end
                        OP_COUNT: begin
                            n_out.status = ST_COUNT;
                        end
                        OP_LIST: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_ovalid = r_ovalid && !m_axis_tready;
                                n_idx    = '0;
                                n_lim    = w_list_n;
                                n_state  = S_LIST;
                            end
                        end
                        default: begin
                            // Undefined op: drop without a result
                            n_ovalid = r_ovalid && !m_axis_tready;
                        end
                    endcase
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                    if (r_upd_found) begin
                        w_cell_op    = CELL_INS;
                        n_count      = r_count + CW'(1);
                        n_out.status = ST_UPDATED;
                    end else if (w_full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_cell_op    = CELL_INS;
                        n_count      = r_count + CW'(1);
                        n_out.status = ST_ADDED_NEW;
                    end
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    n_ovalid     = 1'b1;
                    n_out.status = ST_ENTRY;
                    n_out.key    = w_ent[r_idx].key;
                    n_out.prio   = w_ent[r_idx].prio;
                    n_out.last   = (CW'(r_idx) + CW'(1) == r_lim);
                    n_idx        = r_idx + IW'(1);
                    if (CW'(r_idx) + CW'(1) == r_lim) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.occ = OCC_W'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovalid    <= 1'b0;
            r_idx       <= '0;
            r_lim       <= '0;
            r_upd_found <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovalid    <= n_ovalid;
            r_idx       <= n_idx;
            r_lim       <= n_lim;
            r_upd_found <= n_upd_found;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_upd_ent <= n_upd_ent;
    end

    // Drive the output transaction
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {7'd0, r_out.occ, r_out.prio, r_out.key, r_out.status};

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(DEPTH), "fill count above depth")
    `SPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n,
        w_accept && w_op == OP_INSERT && !w_full,
        r_count == $past(r_count) + CW'(1), "insert did not grow the queue")
    `SPQ_ASSERT_NEXT(a_serve_shrinks, i_clk, i_rst_n,
        w_accept && w_op == OP_SERVE && !w_empty,
        r_count == $past(r_count) - CW'(1), "serve did not shrink the queue")
    `SPQ_ASSERT_NOW(a_list_index, i_clk, i_rst_n, r_state == S_LIST,
        CW'(r_idx) < r_lim, "list index past its end")

endmodule

FILE: dv/tb_stable_priority_queue_with_removal_top.sv
// Self-checking testbench for the stable sorted priority queue with removal.
// Runs directed corner cases and a full-queue test, then random traffic under several idle and stall phases.
// Depends on spq_pkg and stable_priority_queue_with_removal_top.
module tb_stable_priority_queue_with_removal_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QDEPTH       = DEPTH_DEF;
    localparam int SETTLE_LIMIT = 4 * MAX_OUT;
    localparam int PRINT_LIMIT  = 100;

    // Opcodes with no defined behavior; the block must ignore them
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // op[2:0], key[18:3], prio[34:19], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // status[3:0], out_key[19:4], out_prio[35:20],
                                       // occupancy[40:36], zero pad
    logic        m_axis_tlast;

    // Shadow copy of the queue contents
    logic [KEY_W-1:0]         held_keys  [QDEPTH];
    logic signed [PRIO_W-1:0] held_prios [QDEPTH];
    int                       held_count = 0;
    t_result                  pending_results [$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    stable_priority_queue_with_removal_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Insert after every entry of equal priority; refuse when full
    function automatic bit place_entry(input logic [KEY_W-1:0] key,
                                       input logic signed [PRIO_W-1:0] prio);
        int pos;
        int i;
        if (held_count >= QDEPTH)
            return 1'b0;
        pos = 0;
        while (pos < held_count && held_prios[pos] <= prio)
            pos++;
        for (i = held_count; i > pos; i--) begin
            held_keys[i]  = held_keys[i-1];
            held_prios[i] = held_prios[i-1];
        end
        held_keys[pos]  = key;
        held_prios[pos] = prio;
        held_count++;
        return 1'b1;
    endfunction

    // Remove the first entry carrying the key
    function automatic bit drop_entry(input logic [KEY_W-1:0] key);
        int pos;
        int i;
        pos = 0;
        while (pos < held_count && held_keys[pos] != key)
            pos++;
        if (pos >= held_count)
            return 1'b0;
        for (i = pos; i + 1 < held_count; i++) begin
            held_keys[i]  = held_keys[i+1];
            held_prios[i] = held_prios[i+1];
        end
        held_count--;
        return 1'b1;
    endfunction

    function automatic void push_result(input logic [STATUS_W-1:0] status,
                                        input logic [KEY_W-1:0] key,
                                        input logic signed [PRIO_W-1:0] prio,
                                        input logic last);
        t_result res;
        res.status = status;
        res.key    = key;
        res.prio   = prio;
        res.occ    = OCC_W'(held_count);
        res.last   = last;
        pending_results.push_back(res);
    endfunction

    // Apply one accepted operation to the shadow queue and queue its results
    function automatic void apply_operation(input logic [OP_W-1:0] op,
                                            input logic [KEY_W-1:0] key,
                                            input logic signed [PRIO_W-1:0] prio);
        logic [KEY_W-1:0]         head_key;
        logic signed [PRIO_W-1:0] head_prio;
        int                       n;
        int                       i;
        case (op)
            OP_INSERT: begin
                if (place_entry(key, prio))
                    push_result(ST_ADDED, '0, '0, 1'b1);
                else
                    push_result(ST_FULL, '0, '0, 1'b1);
            end
            OP_REMOVE: begin
                if (held_count == 0)
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                else if (drop_entry(key))
                    push_result(ST_REMOVED, '0, '0, 1'b1);
                else
                    push_result(ST_NOT_FOUND, '0, '0, 1'b1);
            end
            OP_UPDATE: begin
                if (drop_entry(key)) begin
                    void'(place_entry(key, prio));
                    push_result(ST_UPDATED, '0, '0, 1'b1);
                end else if (place_entry(key, prio)) begin
                    push_result(ST_ADDED_NEW, '0, '0, 1'b1);
                end else begin
                    push_result(ST_FULL, '0, '0, 1'b1);
                end
            end
            OP_SERVE: begin
                if (held_count == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    head_key  = held_keys[0];
                    head_prio = held_prios[0];
                    void'(drop_entry(head_key));
                    push_result(ST_SERVED, head_key, head_prio, 1'b1);
                end
            end
            OP_COUNT: push_result(ST_COUNT, '0, '0, 1'b1);
            OP_LIST: begin
                if (held_count == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    n = (held_count < MAX_OUT) ? held_count : MAX_OUT;
                    for (i = 0; i < n; i++)
                        push_result(ST_ENTRY, held_keys[i], held_prios[i], i + 1 == n);
                end
            end
            default: ;
        endcase
    endfunction

    // Send one transaction, idling first at the phase's rate; valid stays high after it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic signed [PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, prio, key, op};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        apply_operation(op, key, prio);
    endtask

    // Stall the result side at the phase's rate
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[3:0];
            got.key    = m_axis_tdata[19:4];
            got.prio   = m_axis_tdata[35:20];
            got.occ    = m_axis_tdata[40:36];
            got.last   = m_axis_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d key %h",
                                          got.status, got.key));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.key !== want.key)
                    report_mismatch($sformatf("key %h, expected %h", got.key, want.key));
                if (got.prio !== want.prio)
                    report_mismatch($sformatf("prio %0d, expected %0d",
                                              got.prio, want.prio));
                if (got.occ !== want.occ)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              got.occ, want.occ));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              got.last, want.last));
            end
        end
    end

    // Mostly keys already held or from a small pool, so removes and updates hit
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 50 && held_count > 0)
            return held_keys[$urandom_range(held_count - 1)];
        if (r < 75)
            return KEY_W'($urandom_range(7));
        return KEY_W'($urandom);
    endfunction

    // Narrow range for ties, some extremes, the rest anywhere
    function automatic logic signed [PRIO_W-1:0] pick_prio();
        int                       r;
        logic signed [PRIO_W-1:0] v;
        r = $urandom_range(99);
        if (r < 40) begin
            v = PRIO_W'($urandom_range(4));
            return v - 16'sd2;
        end
        if (r < 50)
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        return PRIO_W'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input bit filling);
        int r;
        r = $urandom_range(99);
        if (filling) begin
            if (r < 55) return OP_INSERT;
            if (r < 70) return OP_UPDATE;
            if (r < 78) return OP_REMOVE;
            if (r < 85) return OP_SERVE;
            if (r < 90) return OP_COUNT;
            return OP_LIST;
        end
        if (r < 10) return OP_INSERT;
        if (r < 45) return OP_SERVE;
        if (r < 75) return OP_REMOVE;
        if (r < 85) return OP_UPDATE;
        if (r < 90) return OP_COUNT;
        return OP_LIST;
    endfunction

    // Empty-queue cases, extremes, ties, update both ways, undefined opcodes
    task automatic test_directed_corners();
        send_item(OP_SERVE,  16'h0000, 16'sd0);
        send_item(OP_REMOVE, 16'h1234, 16'sd0);
        send_item(OP_LIST,   16'h0000, 16'sd0);
        send_item(OP_COUNT,  16'hFFFF, 16'sh7FFF);
        send_item(OP_INSERT, 16'h0000, 16'sh8000);
        send_item(OP_INSERT, 16'hFFFF, 16'sh7FFF);
        send_item(OP_INSERT, 16'h0011, 16'sd0);
        send_item(OP_INSERT, 16'h0022, 16'sd0);
        send_item(OP_INSERT, 16'h0033, -16'sd1);
        send_item(OP_INSERT, 16'h0033, 16'sh7FFF);
        send_item(OP_LIST,   16'h0000, 16'sd0);
        // equal priority: the updated entry moves behind its tie
        send_item(OP_UPDATE, 16'h0011, 16'sd0);
        send_item(OP_UPDATE, 16'h0BAD, 16'sd100);
        send_item(OP_REMOVE, 16'h7777, 16'sd0);
        send_item(OP_REMOVE, 16'h0022, 16'sd0);
        send_item(OP_REMOVE, 16'h0033, 16'sd0);
        send_item(OP_RSVD_LO, 16'hFFFF, 16'sh7FFF);
        send_item(OP_RSVD_HI, 16'h0000, 16'sh8000);
        send_item(OP_LIST,   16'h0000, 16'sd0);
        send_item(OP_SERVE,  16'h0000, 16'sd0);
        send_item(OP_COUNT,  16'h0000, 16'sd0);
    endtask

    // Fill to capacity, hit every full-queue case, list all, then drain
    task automatic test_full_queue();
        logic [KEY_W-1:0] absent_key;
        bit               held;
        int               i;
        while (held_count < QDEPTH)
            send_item(OP_INSERT, pick_key(), pick_prio());
        send_item(OP_INSERT, pick_key(), pick_prio());
        do begin
            absent_key = KEY_W'($urandom);
            held = 1'b0;
            for (i = 0; i < held_count; i++)
                if (held_keys[i] == absent_key)
                    held = 1'b1;
        end while (held);
        send_item(OP_UPDATE, absent_key, pick_prio());
        send_item(OP_UPDATE, held_keys[$urandom_range(QDEPTH - 1)], pick_prio());
        send_item(OP_LIST, '0, '0);
        send_item(OP_COUNT, '0, '0);
        while (held_count > 0)
            send_item(OP_SERVE, pick_key(), pick_prio());
        send_item(OP_SERVE, '0, '0);
    endtask

    // Alternate fill-heavy and drain-heavy bursts with a little noise
    task automatic test_random_traffic(input int n_items);
        int  done;
        int  burst_left;
        bit  filling;
        done       = 0;
        burst_left = 0;
        filling    = 1'b0;
        while (done < n_items) begin
            if (burst_left == 0) begin
                filling    = !filling;
                burst_left = $urandom_range(24, 8);
            end
            if ($urandom_range(99) < 3) begin
                send_item($urandom_range(1) ? OP_RSVD_HI : OP_RSVD_LO,
                          KEY_W'($urandom), PRIO_W'($urandom));
            end else begin
                send_item(pick_op(filling), pick_key(), pick_prio());
                done++;
                burst_left--;
            end
        end
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic finish_traffic();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_LIMIT) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_full_queue();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(30);
        send_idle_pct  = 66;
        recv_stall_pct = 0;
        test_random_traffic(30);
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        test_random_traffic(30);
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        test_random_traffic(30);

        finish_traffic();
        if (error_count == 0)
            $display("tb_stable_priority_queue_with_removal_top OK");
        else
            $display("tb_stable_priority_queue_with_removal_top NOT OK");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("tb_stable_priority_queue_with_removal_top NOT OK");
        $finish;
    end

endmodule
